@@ rtl/htsd_pkg.sv @@
// Shared types and constants for the Huffman tree stream decoder.
package htsd_pkg;

   localparam int NODE_COUNT  = 512;
   localparam int MAX_SYMBOLS = 65536;

   localparam int STORE_SLOTS = 512;
   localparam int STACK_SLOTS = 256;

   localparam int NODE_AW  = $clog2(STORE_SLOTS);
   localparam int NODE_W   = NODE_AW + 1;
   localparam int NID_W    = NODE_AW + 1;
   localparam int STACK_AW = $clog2(STACK_SLOTS);
   localparam int STACK_W  = NODE_AW;
   localparam int DEPTH_W  = STACK_AW + 1;
   localparam int COUNT_W  = 17;
   localparam int SYM_W    = 8;
   localparam int BITCNT_W = $clog2(SYM_W);

   // node entry: top bit marks a leaf, low bits hold byte or right child id
   localparam int LEAF_BIT = NODE_W - 1;

   localparam logic OP_START = 1'b0;
   localparam logic OP_BIT   = 1'b1;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_FLAG = 2'd1;
   localparam logic [1:0] PH_LEAF = 2'd2;
   localparam logic [1:0] PH_DATA = 2'd3;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last_symbol;
      logic             malformed;
   } result_type;

   typedef struct packed {
      logic               rd_en;
      logic [NODE_AW-1:0] rd_addr;
      logic               wr_en;
      logic [NODE_AW-1:0] wr_addr;
      logic [NODE_W-1:0]  wr_data;
   } node_req_type;

   typedef struct packed {
      logic                rd_en;
      logic [STACK_AW-1:0] rd_addr;
      logic                wr_en;
      logic [STACK_AW-1:0] wr_addr;
      logic [STACK_W-1:0]  wr_data;
   } stack_req_type;

endpackage

@@ rtl/huffman_tree_stream_decoder.sv @@
// Top level of the Huffman tree stream decoder.
//
//  channel | direction | handshake          | beat carries
//  req_    | in        | req_valid/ready    | opcode, bit_value, symbol_count
//  rsp_    | out       | rsp_valid/ready    | symbol, last_symbol, malformed
//
// Each beat is taken in an accept cycle, which issues the node-store or stack
// read; the next cycle resolves it from the registered read data.
// A result is pushed in its resolve cycle into a two-entry queue, which holds
// results. req_ready is low in every resolve cycle and while that queue is full.
// Reset clears control state only; the node store and stack are not cleared.
module huffman_tree_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic        req_bit_value,
   input  logic [16:0] req_symbol_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_symbol,
   output logic        rsp_last_symbol,
   output logic        rsp_malformed
);
   import htsd_pkg::*;

   node_req_type        node_req;
   stack_req_type       stack_req;
   logic [NODE_W-1:0]   node_rd_data;
   logic [STACK_W-1:0]  stack_rd_data;
   logic                out_full;
   logic                res_push;
   result_type          res;

   htsd_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_bit_value    (req_bit_value),
      .req_symbol_count (req_symbol_count),
      .out_full         (out_full),
      .res_push         (res_push),
      .res              (res),
      .node_req         (node_req),
      .node_rd_data     (node_rd_data),
      .stack_req        (stack_req),
      .stack_rd_data    (stack_rd_data)
   );

   htsd_ram #(
      .WIDTH (NODE_W),
      .DEPTH (STORE_SLOTS)
   ) u_node_store (
      .clock   (clock),
      .rd_en   (node_req.rd_en),
      .rd_addr (node_req.rd_addr),
      .rd_data (node_rd_data),
      .wr_en   (node_req.wr_en),
      .wr_addr (node_req.wr_addr),
      .wr_data (node_req.wr_data)
   );

   htsd_ram #(
      .WIDTH (STACK_W),
      .DEPTH (STACK_SLOTS)
   ) u_pending_stack (
      .clock   (clock),
      .rd_en   (stack_req.rd_en),
      .rd_addr (stack_req.rd_addr),
      .rd_data (stack_rd_data),
      .wr_en   (stack_req.wr_en),
      .wr_addr (stack_req.wr_addr),
      .wr_data (stack_req.wr_data)
   );

   htsd_out_fifo u_out_fifo (
      .clock           (clock),
      .reset           (reset),
      .push            (res_push),
      .push_data       (res),
      .full            (out_full),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_symbol      (rsp_symbol),
      .rsp_last_symbol (rsp_last_symbol),
      .rsp_malformed   (rsp_malformed)
   );

endmodule

@@ rtl/htsd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module htsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/htsd_out_fifo.sv @@
// Two-entry result queue between the decode sequencer and the rsp channel.
module htsd_out_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  htsd_pkg::result_type push_data,
   output logic                 full,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_symbol,
   output logic                 rsp_last_symbol,
   output logic                 rsp_malformed
);
   import htsd_pkg::*;

   result_type entry_ff [2];
   logic       head_ff, head_in;
   logic       tail_ff, tail_in;
   logic [1:0] count_ff, count_in;
   logic       pop;
   result_type head_data;

   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign pop       = rsp_valid && rsp_ready;
   assign head_data = entry_ff[head_ff];

   assign rsp_symbol      = head_data.symbol;
   assign rsp_last_symbol = head_data.last_symbol;
   assign rsp_malformed   = head_data.malformed;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = ~tail_ff;
      end
      if (pop) begin
         head_in = ~head_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         tail_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

endmodule

@@ rtl/htsd_ctrl.sv @@
// Decode sequencer: tree rebuild and tree walk over the node store and stack.
module htsd_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic                              req_bit_value,
   input  logic [htsd_pkg::COUNT_W-1:0]      req_symbol_count,
   input  logic                              out_full,
   output logic                              res_push,
   output htsd_pkg::result_type              res,
   output htsd_pkg::node_req_type            node_req,
   input  logic [htsd_pkg::NODE_W-1:0]       node_rd_data,
   output htsd_pkg::stack_req_type           stack_req,
   input  logic [htsd_pkg::STACK_W-1:0]      stack_rd_data
);
   import htsd_pkg::*;

   // accept stage -> resolve stage
   logic               s1_valid_ff;
   logic               s1_op_ff;
   logic               s1_bit_ff;
   logic [COUNT_W-1:0] s1_cnt_ff;
   logic [NODE_AW-1:0] s1_next_ff;

   logic [1:0]          phase_ff, phase_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [NID_W-1:0]    nid_ff, nid_in;
   logic [SYM_W-1:0]    shift_ff, shift_in;
   logic [BITCNT_W-1:0] bitcnt_ff, bitcnt_in;
   logic [NODE_AW-1:0]  current_ff, current_in;
   logic [COUNT_W-1:0]  left_ff, left_in;
   logic [NODE_W-1:0]   cur_entry_ff, cur_entry_in;
   logic [NODE_W-1:0]   root_entry_ff;

   logic               req_accept;
   logic               s1_bit_op;
   logic               leaf_last_bit;
   logic               leaf_done_acc;
   logic               data_rd_acc;
   logic               parent_wr;
   logic               push_wr;
   logic               node_full;
   logic               stack_full;
   logic [NODE_AW-1:0] walk_next;
   logic [NID_W-1:0]   nid_inc;
   logic [DEPTH_W-1:0] depth_dec;
   logic [SYM_W-1:0]   leaf_byte;
   logic [COUNT_W-1:0] cnt_sat;
   logic [COUNT_W-1:0] left_dec;
   logic               emit;
   logic [SYM_W-1:0]   emit_byte;

   assign req_ready  = !s1_valid_ff && !out_full;
   assign req_accept = req_valid && req_ready;

   assign s1_bit_op     = s1_valid_ff && (s1_op_ff == OP_BIT);
   assign leaf_last_bit = (bitcnt_ff == BITCNT_W'(SYM_W - 1));
   assign node_full     = (nid_ff >= NID_W'(NODE_COUNT));
   assign stack_full    = (depth_ff >= DEPTH_W'(STACK_SLOTS));
   assign nid_inc       = nid_ff + NID_W'(1);
   assign depth_dec     = depth_ff - DEPTH_W'(1);
   assign leaf_byte     = {req_bit_value, shift_ff[SYM_W-1:1]};

   // child chosen by the incoming bit; left child is always the next id
   assign walk_next = req_bit_value ? cur_entry_ff[NODE_AW-1:0]
                                    : current_ff + NODE_AW'(1);

   assign leaf_done_acc = req_accept && (req_opcode == OP_BIT) &&
                          (phase_ff == PH_LEAF) && leaf_last_bit;
   assign data_rd_acc   = req_accept && (req_opcode == OP_BIT) &&
                          (phase_ff == PH_DATA) && !cur_entry_ff[LEAF_BIT];
   assign parent_wr     = s1_bit_op && (phase_ff == PH_LEAF) && leaf_last_bit &&
                          (depth_ff != '0);
   assign push_wr       = s1_bit_op && (phase_ff == PH_FLAG) && !s1_bit_ff &&
                          !node_full && !stack_full;

   // leaf entry goes in on the accept cycle, parent link on the resolve cycle
   always_comb begin
      node_req.rd_en   = data_rd_acc;
      node_req.rd_addr = walk_next;
      node_req.wr_en   = leaf_done_acc || parent_wr;
      if (parent_wr) begin
         node_req.wr_addr = stack_rd_data[NODE_AW-1:0];
         node_req.wr_data = {1'b0, nid_inc[NODE_AW-1:0]};
      end else begin
         node_req.wr_addr = nid_ff[NODE_AW-1:0];
         node_req.wr_data = {1'b1, (NODE_AW - SYM_W)'(0), leaf_byte};
      end
   end

   always_comb begin
      stack_req.rd_en   = leaf_done_acc;
      stack_req.rd_addr = depth_dec[STACK_AW-1:0];
      stack_req.wr_en   = push_wr;
      stack_req.wr_addr = depth_ff[STACK_AW-1:0];
      stack_req.wr_data = nid_ff[NODE_AW-1:0];
   end

   assign cnt_sat  = (32'(s1_cnt_ff) > 32'(MAX_SYMBOLS)) ? COUNT_W'(MAX_SYMBOLS)
                                                          : s1_cnt_ff;
   assign left_dec = (left_ff != '0) ? left_ff - COUNT_W'(1) : left_ff;

   always_comb begin
      phase_in     = phase_ff;
      depth_in     = depth_ff;
      nid_in       = nid_ff;
      shift_in     = shift_ff;
      bitcnt_in    = bitcnt_ff;
      current_in   = current_ff;
      left_in      = left_ff;
      cur_entry_in = cur_entry_ff;
      res_push     = 1'b0;
      res          = '0;
      emit         = 1'b0;
      emit_byte    = '0;

      if (s1_valid_ff && (s1_op_ff == OP_START)) begin
         left_in    = cnt_sat;
         depth_in   = '0;
         nid_in     = NID_W'(1);
         shift_in   = '0;
         bitcnt_in  = '0;
         current_in = NODE_AW'(1);
         phase_in   = (cnt_sat != '0) ? PH_FLAG : PH_IDLE;
      end else if (s1_bit_op) begin
         case (phase_ff)
            PH_FLAG: begin
               if (node_full || (!s1_bit_ff && stack_full)) begin
                  phase_in      = PH_IDLE;
                  left_in       = '0;
                  res_push      = 1'b1;
                  res.malformed = 1'b1;
               end else if (s1_bit_ff) begin
                  shift_in  = '0;
                  bitcnt_in = '0;
                  phase_in  = PH_LEAF;
               end else begin
                  depth_in = depth_ff + DEPTH_W'(1);
                  nid_in   = nid_inc;
               end
            end
            PH_LEAF: begin
               shift_in  = {s1_bit_ff, shift_ff[SYM_W-1:1]};
               bitcnt_in = bitcnt_ff + BITCNT_W'(1);
               if (leaf_last_bit) begin
                  nid_in = nid_inc;
                  if (depth_ff == '0) begin
                     phase_in     = PH_DATA;
                     current_in   = NODE_AW'(1);
                     cur_entry_in = root_entry_ff;
                  end else begin
                     depth_in = depth_dec;
                     phase_in = PH_FLAG;
                  end
               end
            end
            PH_DATA: begin
               if (cur_entry_ff[LEAF_BIT]) begin
                  emit      = 1'b1;
                  emit_byte = cur_entry_ff[SYM_W-1:0];
               end else if (node_rd_data[LEAF_BIT]) begin
                  emit      = 1'b1;
                  emit_byte = node_rd_data[SYM_W-1:0];
               end else begin
                  current_in   = s1_next_ff;
                  cur_entry_in = node_rd_data;
               end
            end
            default: begin
            end
         endcase

         if (emit) begin
            left_in          = left_dec;
            current_in       = NODE_AW'(1);
            cur_entry_in     = root_entry_ff;
            res_push         = 1'b1;
            res.symbol       = emit_byte;
            res.last_symbol  = (left_dec == '0);
            if (left_dec == '0) begin
               phase_in = PH_IDLE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         phase_ff     <= PH_IDLE;
         depth_ff     <= '0;
         nid_ff       <= NID_W'(1);
         shift_ff     <= '0;
         bitcnt_ff    <= '0;
         current_ff   <= NODE_AW'(1);
         left_ff      <= '0;
      end else begin
         s1_valid_ff  <= req_accept;
         phase_ff     <= phase_in;
         depth_ff     <= depth_in;
         nid_ff       <= nid_in;
         shift_ff     <= shift_in;
         bitcnt_ff    <= bitcnt_in;
         current_ff   <= current_in;
         left_ff      <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_entry_ff <= cur_entry_in;
      if (req_accept) begin
         s1_op_ff   <= req_opcode;
         s1_bit_ff  <= req_bit_value;
         s1_cnt_ff  <= req_symbol_count;
         s1_next_ff <= walk_next;
      end
      // shadow copy of the root entry so a walk can restart without a read
      if (node_req.wr_en && (node_req.wr_addr == NODE_AW'(1))) begin
         root_entry_ff <= node_req.wr_data;
      end
   end

`ifndef SYNTH
   a_reads_on_accept_only: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !(node_req.rd_en || stack_req.rd_en))
      else $error("memory read issued during resolve cycle");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !out_full)
      else $error("result pushed into full queue");

   a_nid_bounded: assert property (@(posedge clock) disable iff (reset)
      nid_ff <= NID_W'(NODE_COUNT))
      else $error("node id ran past node store");

   a_walk_with_empty_stack: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (depth_ff == '0))
      else $error("tree walk entered with pending internal nodes");
`endif

endmodule
